### rtl/rwfp_pkg.sv
// Package for the readout word frame parser.
// Word codes, result status codes, hit layout and controller/datapath interface structs.
// No dependencies.
`default_nettype none

package rwfp_pkg;

    localparam int WORD_W     = 32;
    localparam int LEFT_W     = 16;
    localparam int HIT_W      = 53;
    localparam int HT_W       = 16;
    localparam int LT_W       = 30;
    localparam int STATUS_W   = 3;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 184;

    // top nibble of a readout word
    localparam logic [3:0] NIB_FILL   = 4'h0;
    localparam logic [3:0] NIB_DATA2  = 4'h1;
    localparam logic [3:0] NIB_EXTTS  = 4'h2;
    localparam logic [3:0] NIB_DATA1  = 4'h3;
    localparam logic [3:0] NIB_HEADER = 4'h4;
    localparam logic [1:0] EOE_MARK   = 2'b11;

    localparam logic [STATUS_W-1:0] ST_HIT     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TIME    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOTIME  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SIZE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd4;

    // hit layout: adc 11:0, channel 23:12, time difference 39:24, bus 43:40,
    // module 51:44, ext_trigger 52
    typedef logic [HIT_W-1:0] hit_t;

    typedef struct packed {
        logic take;       // input transaction this cycle
        logic rd_issue;   // read hit store at flush index
        logic load_word;  // load output register from decoded word
        logic load_hit;   // load output register from hit store read data
    } cmd_t;

    typedef struct packed {
        logic one_res;    // accepted word gives one result
        logic flush;      // accepted word ends buffer with stored hits
        logic last_hit;   // flush index at last stored hit
    } stat_t;

endpackage

`default_nettype wire

### rtl/readout_word_frame_parser.sv
// Top level of the readout word frame parser.
// Joins rwfp_ctrl and rwfp_dp; packs the stream payloads. Uses rwfp_pkg.
//
// channel   dir   width          transaction
// s_*       in    tdata 48, tlast one readout word
// m_*       out   tdata 184, tuser 3, tlast   one result item
// cfg_*     in    data 1         high-time spoof enable write
//
// A last word with N stored hits is followed by a flush (registered hit store read, then
// output load, for each hit) with s_tready low.
// Other results are loaded into the output register as the word is taken.
// Outside a flush, input stalls only while the output register holds an item not yet taken.
// Reset clears control state; the hit store needs no clearing.
`default_nettype none

module readout_word_frame_parser #(
    parameter int MAX_HITS = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // word [31:0], words_left [47:32]
    input  wire logic [rwfp_pkg::IN_DATA_W-1:0]      s_tdata,
    input  wire logic                                s_tlast,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // module_res [7:0], bus [11:8], time difference [27:12], channel [39:28],
    // adc [51:40], ext_trigger [52], trigger_number [84:53], high time [100:85],
    // low time [130:101], full time [176:131], zero [183:177]
    output logic [rwfp_pkg::OUT_DATA_W-1:0]          m_tdata,
    // status [2:0]
    output logic [rwfp_pkg::STATUS_W-1:0]            m_tuser,
    output logic                                     m_tlast,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic                                cfg_data
);

    rwfp_pkg::cmd_t                  cmd;
    rwfp_pkg::stat_t                 stat;
    rwfp_pkg::hit_t                  out_hit;
    logic [31:0]                     out_trig;
    logic [rwfp_pkg::HT_W-1:0]       out_hi;
    logic [rwfp_pkg::LT_W-1:0]       out_lo;

    assign cfg_ready = 1'b1;

    rwfp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rwfp_dp #(
        .MAX_HITS (MAX_HITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .word       (s_tdata[31:0]),
        .last       (s_tlast),
        .words_left (s_tdata[47:32]),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .stat       (stat),
        .out_status (m_tuser),
        .out_hit    (out_hit),
        .out_trig   (out_trig),
        .out_hi     (out_hi),
        .out_lo     (out_lo),
        .out_final  (m_tlast)
    );

    // full time is high time * 2^30 + low time, a plain concatenation
    assign m_tdata = {7'd0, out_hi, out_lo, out_lo, out_hi, out_trig, out_hit[52],
                      out_hit[11:0], out_hit[23:12], out_hit[39:24], out_hit[43:40],
                      out_hit[51:44]};

endmodule

`default_nettype wire

### rtl/rwfp_ctrl.sv
// Controller of the readout word frame parser.
// Sequences word intake, hit store flush and the output handshake. Uses rwfp_pkg.
`default_nettype none

module rwfp_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  wire rwfp_pkg::stat_t stat,
    output rwfp_pkg::cmd_t     cmd
);

    typedef enum logic [1:0] {
        S_RUN,
        S_READ,
        S_EMIT
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_RUN) && out_free;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd.take      = s_tvalid && s_tready;
        cmd.rd_issue  = (state_reg == S_READ);
        cmd.load_word = cmd.take && stat.one_res;
        cmd.load_hit  = (state_reg == S_EMIT) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_RUN;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.load_word || cmd.load_hit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_RUN: begin
                    if (cmd.take && stat.flush) begin
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (cmd.load_hit) begin
                        state_reg <= stat.last_hit ? S_RUN : S_READ;
                    end
                end
                default: begin
                    state_reg <= S_RUN;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/rwfp_dp.sv
// Datapath of the readout word frame parser.
// Word decoding, buffer state, hit store memory and output register. Uses rwfp_pkg.
`default_nettype none

module rwfp_dp #(
    parameter int MAX_HITS = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [rwfp_pkg::WORD_W-1:0]       word,
    input  wire logic                              last,
    input  wire logic [rwfp_pkg::LEFT_W-1:0]       words_left,
    input  wire logic                              cfg_we,
    input  wire logic                              cfg_data,
    input  wire rwfp_pkg::cmd_t                    cmd,
    output rwfp_pkg::stat_t                        stat,
    output logic [rwfp_pkg::STATUS_W-1:0]          out_status,
    output rwfp_pkg::hit_t                         out_hit,
    output logic [31:0]                            out_trig,
    output logic [rwfp_pkg::HT_W-1:0]              out_hi,
    output logic [rwfp_pkg::LT_W-1:0]              out_lo,
    output logic                                   out_final
);

    localparam int CW = $clog2(MAX_HITS + 1);
    localparam int IW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_HITS);

    rwfp_pkg::hit_t                  mem [MAX_HITS];
    rwfp_pkg::hit_t                  rd_data_reg;
    logic [IW-1:0]                   rd_idx_reg;

    logic [51:0]                     cur_reg, cur_next;
    logic [rwfp_pkg::LT_W-1:0]       flt_reg, flt_next;
    logic                            seen_reg, seen_next;
    logic                            ab_reg, ab_next;
    logic                            mid_reg, mid_next;
    logic [rwfp_pkg::HT_W-1:0]       ht_reg, ht_next;
    logic [rwfp_pkg::LT_W-1:0]       prev_reg, prev_next;
    logic [31:0]                     buf_reg, buf_next;
    logic [CW-1:0]                   cnt_reg, cnt_next;
    logic                            spoof_reg;

    logic [51:0]                     eff_cur;
    logic [CW-1:0]                   eff_cnt;
    logic                            do_store;
    rwfp_pkg::hit_t                  store_val;
    logic                            one_res;
    logic [rwfp_pkg::STATUS_W-1:0]   one_status;
    rwfp_pkg::hit_t                  one_hit;
    logic [rwfp_pkg::HT_W-1:0]       one_hi;
    logic [rwfp_pkg::LT_W-1:0]       one_lo;
    logic                            flush;
    logic                            abort;
    logic [rwfp_pkg::STATUS_W-1:0]   ab_status;

    rwfp_pkg::hit_t                  out_hit_reg;
    logic [rwfp_pkg::STATUS_W-1:0]   out_status_reg;
    logic [31:0]                     out_trig_reg;
    logic [rwfp_pkg::HT_W-1:0]       out_hi_reg;
    logic [rwfp_pkg::LT_W-1:0]       out_lo_reg;
    logic                            out_final_reg;

    always_comb begin
        eff_cur    = mid_reg ? cur_reg : 52'd0;
        eff_cnt    = mid_reg ? cnt_reg : '0;
        cur_next   = eff_cur;
        flt_next   = mid_reg ? flt_reg : '0;
        seen_next  = mid_reg ? seen_reg : 1'b0;
        ab_next    = mid_reg ? ab_reg : 1'b0;
        buf_next   = mid_reg ? buf_reg : buf_reg + 32'd1;
        cnt_next   = eff_cnt;
        ht_next    = ht_reg;
        prev_next  = prev_reg;
        mid_next   = !last;
        do_store   = 1'b0;
        store_val  = '0;
        abort      = 1'b0;
        ab_status  = rwfp_pkg::ST_UNKNOWN;
        one_res    = 1'b0;
        one_status = rwfp_pkg::ST_HIT;
        one_hit    = '0;
        one_hi     = '0;
        one_lo     = '0;
        flush      = 1'b0;

        if (!ab_next) begin
            unique case (word[31:28])
                rwfp_pkg::NIB_HEADER: begin
                    cur_next[51:44] = word[23:16];
                    if (word[24]) begin
                        do_store  = 1'b1;
                        store_val = {1'b1, cur_next};
                    end
                    if ({6'd0, word[9:0]} > words_left) begin
                        abort     = 1'b1;
                        ab_status = rwfp_pkg::ST_SIZE;
                    end
                end
                rwfp_pkg::NIB_EXTTS: begin
                    if (!spoof_reg) begin
                        ht_next = word[15:0];
                    end
                end
                rwfp_pkg::NIB_DATA1: begin
                    cur_next[43:40] = word[27:24];
                    cur_next[39:24] = word[15:0];
                end
                rwfp_pkg::NIB_DATA2: begin
                    cur_next[43:40] = word[27:24];
                    cur_next[23:12] = word[23:12];
                    cur_next[11:0]  = word[11:0];
                    do_store        = 1'b1;
                    store_val       = {1'b0, cur_next};
                end
                rwfp_pkg::NIB_FILL: begin
                end
                default: begin
                    if (word[31:30] == rwfp_pkg::EOE_MARK) begin
                        flt_next  = word[29:0];
                        seen_next = 1'b1;
                    end else begin
                        abort     = 1'b1;
                        ab_status = rwfp_pkg::ST_UNKNOWN;
                    end
                end
            endcase

            if (do_store && (eff_cnt < CNT_MAX)) begin
                cnt_next = eff_cnt + CW'(1);
            end

            priority if (abort) begin
                ab_next    = 1'b1;
                cnt_next   = '0;
                one_res    = 1'b1;
                one_status = ab_status;
            end else if (last) begin
                if (!seen_next) begin
                    cnt_next   = '0;
                    one_res    = 1'b1;
                    one_status = rwfp_pkg::ST_NOTIME;
                end else begin
                    if (spoof_reg) begin
                        if (flt_next < prev_reg) begin
                            ht_next = ht_reg + 16'd1;
                        end
                        prev_next = flt_next;
                    end
                    if (cnt_next == '0) begin
                        one_res    = 1'b1;
                        one_status = rwfp_pkg::ST_TIME;
                        one_hit    = {1'b0, cur_next[51:44], 44'd0};
                        one_hi     = ht_next;
                        one_lo     = flt_next;
                    end else begin
                        flush = 1'b1;
                    end
                end
            end else begin
            end
        end
    end

    always_comb begin
        stat.one_res  = one_res;
        stat.flush    = flush;
        stat.last_hit = (CW'(rd_idx_reg) + CW'(1)) == cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg   <= '0;
            flt_reg   <= '0;
            seen_reg  <= 1'b0;
            ab_reg    <= 1'b0;
            mid_reg   <= 1'b0;
            ht_reg    <= '0;
            prev_reg  <= '0;
            buf_reg   <= '0;
            cnt_reg   <= '0;
            spoof_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                spoof_reg <= cfg_data;
            end
            if (cmd.take) begin
                cur_reg  <= cur_next;
                flt_reg  <= flt_next;
                seen_reg <= seen_next;
                ab_reg   <= ab_next;
                mid_reg  <= mid_next;
                ht_reg   <= ht_next;
                prev_reg <= prev_next;
                buf_reg  <= buf_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    // hit store and flush read port
    always_ff @(posedge aclk) begin
        if (cmd.take && !ab_next && do_store && (eff_cnt < CNT_MAX)) begin
            mem[eff_cnt[IW-1:0]] <= store_val;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take && flush) begin
            rd_idx_reg <= '0;
        end else if (cmd.load_hit) begin
            rd_idx_reg <= rd_idx_reg + IW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_word) begin
            out_status_reg <= one_status;
            out_hit_reg    <= one_hit;
            out_trig_reg   <= buf_next;
            out_hi_reg     <= one_hi;
            out_lo_reg     <= one_lo;
            out_final_reg  <= 1'b1;
        end else if (cmd.load_hit) begin
            out_status_reg <= rwfp_pkg::ST_HIT;
            out_hit_reg    <= rd_data_reg;
            out_trig_reg   <= buf_reg;
            out_hi_reg     <= ht_reg;
            out_lo_reg     <= flt_reg;
            out_final_reg  <= stat.last_hit;
        end
    end

    assign out_status = out_status_reg;
    assign out_hit    = out_hit_reg;
    assign out_trig   = out_trig_reg;
    assign out_hi     = out_hi_reg;
    assign out_lo     = out_lo_reg;
    assign out_final  = out_final_reg;

endmodule

`default_nettype wire
